/* sv/slex_pkg.sv */
// Shared types, constants and helper functions for the script lexer.
package slex_pkg;

  // Lexer modes.
  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_SLASH  = 3'd1,
    M_LINE   = 3'd2,
    M_BLOCK  = 3'd3,
    M_BSTAR  = 3'd4,
    M_NUMBER = 3'd5,
    M_IDENT  = 3'd6,
    M_STRING = 3'd7
  } mode_t;

  // Character classes.
  typedef enum logic [2:0] {
    CLS_NUM   = 3'd0,
    CLS_LET   = 3'd1,
    CLS_QUOTE = 3'd2,
    CLS_SYM   = 3'd3,
    CLS_SKIP  = 3'd4
  } class_t;

  // Record kinds.
  localparam logic [1:0] REC_CHAR = 2'd0;
  localparam logic [1:0] REC_END  = 2'd1;
  localparam logic [1:0] REC_ERR  = 2'd2;

  // Token kinds.
  localparam logic [3:0] TKN_NUMBER = 4'd0;
  localparam logic [3:0] TKN_IDENT  = 4'd1;
  localparam logic [3:0] TKN_STRING = 4'd2;
  localparam logic [3:0] TKN_POUND  = 4'd3;
  localparam logic [3:0] TKN_COLON  = 4'd4;
  localparam logic [3:0] TKN_SEMI   = 4'd5;
  localparam logic [3:0] TKN_LBRACE = 4'd6;
  localparam logic [3:0] TKN_RBRACE = 4'd7;
  localparam logic [3:0] TKN_LPAREN = 4'd8;
  localparam logic [3:0] TKN_RPAREN = 4'd9;
  localparam logic [3:0] TKN_COMMA  = 4'd10;
  localparam logic [3:0] TKN_NONE   = 4'd0;

  // Error codes.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_SLASH   = 2'd2;
  localparam logic [1:0] ERR_STRING  = 2'd3;

  // Keyword codes.
  localparam logic [2:0] KW_NONE = 3'd0;
  localparam int         KW_NUM  = 7;

  // Special bytes.
  localparam logic [7:0] DEL_BYTE   = 8'd127;
  localparam logic [7:0] NL_BYTE    = 8'h0A;
  localparam logic [7:0] SLASH_BYTE = "/";
  localparam logic [7:0] STAR_BYTE  = "*";
  localparam logic [7:0] QUOTE_BYTE = "\"";

  // Keyword spellings, lower case, and their lengths.
  localparam logic [7:0] KW_TEXT [0:KW_NUM-1][0:7] = '{
    '{"d", "e", "f", "i", "n", "e", 8'h00, 8'h00},
    '{"i", "n", "c", "l", "u", "d", "e", 8'h00},
    '{"w", "a", "i", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"m", "a", "c", "r", "o", 8'h00, 8'h00, 8'h00},
    '{"s", "e", "t", "d", "i", "r", 8'h00, 8'h00},
    '{"u", "n", "d", "e", "f", 8'h00, 8'h00, 8'h00},
    '{"l", "o", "o", "p", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [0:KW_NUM-1] = '{
    3'd6, 3'd7, 3'd4, 3'd5, 3'd6, 3'd5, 3'd4
  };

  // One output record.
  typedef struct packed {
    logic [1:0]  record_kind;
    logic [7:0]  char_value;
    logic [3:0]  token_kind;
    logic [2:0]  keyword_code;
    logic [8:0]  token_length;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [1:0]  error_code;
    logic        last_of_run;
  } rec_t;

  function automatic rec_t mk_rec(input logic [1:0] kind, input logic [7:0] ch,
                                  input logic [3:0] tk, input logic [2:0] kw,
                                  input logic [8:0] len, input logic [15:0] ln,
                                  input logic [15:0] col, input logic [1:0] err);
    rec_t r;
    r.record_kind  = kind;
    r.char_value   = ch;
    r.token_kind   = tk;
    r.keyword_code = kw;
    r.token_length = len;
    r.start_line   = ln;
    r.start_column = col;
    r.error_code   = err;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  function automatic class_t char_class(input logic [7:0] b);
    class_t c;
    if (b inside {["0":"9"], "-"}) begin
      c = CLS_NUM;
    end else if (b inside {["A":"Z"], ["a":"z"], "_"}) begin
      c = CLS_LET;
    end else if (b == QUOTE_BYTE) begin
      c = CLS_QUOTE;
    end else if (b inside {["!":"~"]}) begin
      c = CLS_SYM;
    end else begin
      c = CLS_SKIP;
    end
    return c;
  endfunction

  // Token kind of a single-character symbol; TKN_NONE when it is not one.
  function automatic logic [3:0] symbol_kind(input logic [7:0] b);
    logic [3:0] k;
    case (b)
      "#":     k = TKN_POUND;
      ":":     k = TKN_COLON;
      ";":     k = TKN_SEMI;
      "{":     k = TKN_LBRACE;
      "}":     k = TKN_RBRACE;
      "(":     k = TKN_LPAREN;
      ")":     k = TKN_RPAREN;
      ",":     k = TKN_COMMA;
      default: k = TKN_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] mode_kind(input mode_t m);
    logic [3:0] k;
    case (m)
      M_IDENT:  k = TKN_IDENT;
      M_STRING: k = TKN_STRING;
      default:  k = TKN_NUMBER;
    endcase
    return k;
  endfunction

  // Keywords that still match when the lowered character sits at position idx.
  // ok is low once the position no longer fits the three-bit index.
  function automatic logic [KW_NUM-1:0] kw_hits(input logic [7:0] low,
                                                input logic [2:0] idx, input logic ok);
    logic [KW_NUM-1:0] h;
    for (int k = 0; k < KW_NUM; k++) begin
      h[k] = ok && (idx < KW_LEN[k]) && (low == KW_TEXT[k][idx]);
    end
    return h;
  endfunction

  // Code of the first surviving keyword whose length equals the token length.
  function automatic logic [2:0] kw_code(input logic [KW_NUM-1:0] mask,
                                         input logic [2:0] len, input logic ok);
    logic [2:0] c;
    c = KW_NONE;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (mask[k] && ok && (len == KW_LEN[k])) begin
        c = 3'(k + 1);
      end
    end
    return c;
  endfunction

endpackage

/* sv/slex_if.sv */
// Channel interfaces of the script lexer: input bytes and output records.
interface slex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_text;

  modport source (output valid, output byte_value, output end_of_text, input ready);
  modport sink (input valid, input byte_value, input end_of_text, output ready);
endinterface

interface slex_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [7:0]  char_value;
  logic [3:0]  token_kind;
  logic [2:0]  keyword_code;
  logic [8:0]  token_length;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [1:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output record_kind, output char_value, output token_kind,
                  output keyword_code, output token_length, output start_line,
                  output start_column, output error_code, output last_of_run,
                  input ready);
  modport sink (input valid, input record_kind, input char_value, input token_kind,
                input keyword_code, input token_length, input start_line,
                input start_column, input error_code, input last_of_run,
                output ready);
endinterface

/* sv/script_lexer_top.sv */
// Top level of the script lexer: byte input register, lexer logic, record buffer.
//
//   channel   direction  transaction
//   in_chan   input      one text byte plus end-of-text flag
//   out_chan  output     one record: token character, token end or error
//
// A byte is taken into the input register and lexed once the record buffer is
// free; its records (zero to three) are loaded into a three-entry record buffer.
// The buffer is free when empty or when its last record leaves; until then the
// input is held. The output port gives one record per cycle while out_chan.ready
// is high. Reset is synchronous; there is no clearing pass. A stalled output
// keeps records in the buffer and backs up into in_chan.ready.
module script_lexer_top
  import slex_pkg::*;
#(
  parameter int TOKEN_LIMIT   = 511,
  parameter int POSITION_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  slex_in_if.sink         in_chan,
  slex_out_if.source      out_chan
);

  localparam int CNT_W = $clog2(TOKEN_LIMIT + 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(TOKEN_LIMIT);
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  // Input register.
  logic       in_full_r;
  logic [7:0] in_byte_r;
  logic       in_eot_r;

  // Lexer state.
  mode_t                  mode_r,  mode_nxt;
  logic [KW_NUM-1:0]      mask_r,  mask_nxt;
  logic [CNT_W-1:0]       cnt_r,   cnt_nxt;
  logic [POSITION_BITS-1:0] line_r, line_nxt;
  logic [POSITION_BITS-1:0] col_r,  col_nxt;
  logic [POSITION_BITS-1:0] tsl_r,  tsl_nxt;
  logic [POSITION_BITS-1:0] tsc_r,  tsc_nxt;

  // Record buffer.
  rec_t       rec_r [0:2];
  logic [1:0] n_r;

  // Handshake control.
  logic proc_fire;
  logic buf_free;
  logic pop;

  // Lexer outputs.
  rec_t       cand [0:3];
  logic [3:0] cand_v;
  rec_t       pack [0:2];
  logic [1:0] pack_n;

  assign pop       = out_chan.valid && out_chan.ready;
  assign buf_free  = (n_r == 2'd0) || ((n_r == 2'd1) && out_chan.ready);
  assign proc_fire = in_full_r && buf_free;
  assign in_chan.ready = !in_full_r || proc_fire;

  // Input register: control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_full_r <= in_chan.valid;
    end
  end

  // Input register: payload.
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.byte_value;
      in_eot_r  <= in_chan.end_of_text;
    end
  end

  // Lexer: mode transition, state update and up to four record slots in order.
  always_comb begin : lex_comb
    logic [7:0]        b_v;
    logic [7:0]        low_v;
    class_t            cls_v;
    logic              idx_ok;
    logic              idx2_ok;
    logic              run_idle;
    logic              add_v;
    logic [3:0]        sk_v;
    logic [CNT_W-1:0]  cnt_inc;
    logic [15:0]       ln16;
    logic [15:0]       col16;
    rec_t              end_rec;
    logic [2:0]        n_v;

    b_v     = (in_byte_r == DEL_BYTE) ? 8'h00 : in_byte_r;
    low_v   = (b_v inside {["A":"Z"]}) ? (b_v | 8'h20) : b_v;
    cls_v   = char_class(b_v);
    sk_v    = symbol_kind(b_v);
    ln16    = 16'(line_r);
    col16   = 16'(col_r);
    idx_ok  = (cnt_r < CNT_W'(8));
    cnt_inc = (cnt_r < CNT_LIMIT) ? cnt_r + CNT_W'(1) : cnt_r;

    mode_nxt = mode_r;
    mask_nxt = mask_r;
    cnt_nxt  = cnt_r;
    tsl_nxt  = tsl_r;
    tsc_nxt  = tsc_r;
    run_idle = 1'b0;
    add_v    = 1'b0;
    cand_v   = 4'b0000;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end

    end_rec = mk_rec(REC_END, 8'h00, mode_kind(mode_r),
                     (mode_r == M_IDENT) ? kw_code(mask_r, cnt_r[2:0], idx_ok) : KW_NONE,
                     9'(cnt_r), 16'(tsl_r), 16'(tsc_r), ERR_NONE);

    // Work of the current mode.
    case (mode_r)
      M_IDLE: begin
        run_idle = 1'b1;
      end
      M_SLASH: begin
        if (b_v == SLASH_BYTE) begin
          mode_nxt = M_LINE;
        end else if (b_v == STAR_BYTE) begin
          mode_nxt = M_BLOCK;
        end else begin
          cand[0]   = mk_rec(REC_ERR, SLASH_BYTE, TKN_NONE, KW_NONE, 9'd0,
                             16'(tsl_r), 16'(tsc_r), ERR_SLASH);
          cand_v[0] = 1'b1;
          mode_nxt  = M_IDLE;
          run_idle  = 1'b1;
        end
      end
      M_LINE: begin
        if (b_v == NL_BYTE) begin
          mode_nxt = M_IDLE;
        end
      end
      M_BLOCK: begin
        if (b_v == STAR_BYTE) begin
          mode_nxt = M_BSTAR;
        end
      end
      M_BSTAR: begin
        if (b_v == SLASH_BYTE) begin
          mode_nxt = M_IDLE;
        end else if (b_v != STAR_BYTE) begin
          mode_nxt = M_BLOCK;
        end
      end
      M_NUMBER, M_IDENT: begin
        if ((mode_r == M_NUMBER && cls_v == CLS_NUM) ||
            (mode_r == M_IDENT && cls_v == CLS_LET)) begin
          add_v = 1'b1;
        end else begin
          cand[0]   = end_rec;
          cand_v[0] = 1'b1;
          mode_nxt  = M_IDLE;
          run_idle  = 1'b1;
        end
      end
      M_STRING: begin
        if (b_v == QUOTE_BYTE) begin
          cand[1]   = end_rec;
          cand_v[1] = 1'b1;
          mode_nxt  = M_IDLE;
        end else begin
          add_v = 1'b1;
        end
      end
      default: begin
        mode_nxt = M_IDLE;
      end
    endcase

    // Character appended to the open token.
    if (add_v) begin
      cand[1]   = mk_rec(REC_CHAR, b_v, mode_kind(mode_r), KW_NONE, 9'd0,
                         16'(tsl_r), 16'(tsc_r), ERR_NONE);
      cand_v[1] = 1'b1;
      mask_nxt  = mask_r & kw_hits(low_v, cnt_r[2:0], idx_ok);
      cnt_nxt   = cnt_inc;
    end

    // Byte seen outside any token: start a token, a slash or a symbol.
    if (run_idle) begin
      case (cls_v)
        CLS_NUM, CLS_LET: begin
          mode_nxt  = (cls_v == CLS_NUM) ? M_NUMBER : M_IDENT;
          cnt_nxt   = CNT_W'(1);
          mask_nxt  = kw_hits(low_v, 3'd0, 1'b1);
          tsl_nxt   = line_r;
          tsc_nxt   = col_r;
          cand[1]   = mk_rec(REC_CHAR, b_v, (cls_v == CLS_NUM) ? TKN_NUMBER : TKN_IDENT,
                             KW_NONE, 9'd0, ln16, col16, ERR_NONE);
          cand_v[1] = 1'b1;
        end
        CLS_QUOTE: begin
          mode_nxt = M_STRING;
          cnt_nxt  = '0;
          mask_nxt = '1;
          tsl_nxt  = line_r;
          tsc_nxt  = col_r;
        end
        CLS_SYM: begin
          if (b_v == SLASH_BYTE) begin
            mode_nxt = M_SLASH;
            tsl_nxt  = line_r;
            tsc_nxt  = col_r;
          end else if (sk_v == TKN_NONE) begin
            cand[1]   = mk_rec(REC_ERR, b_v, TKN_NONE, KW_NONE, 9'd0, ln16, col16,
                               ERR_UNKNOWN);
            cand_v[1] = 1'b1;
          end else begin
            cand[1]   = mk_rec(REC_CHAR, b_v, sk_v, KW_NONE, 9'd0, ln16, col16, ERR_NONE);
            cand[2]   = mk_rec(REC_END, 8'h00, sk_v, KW_NONE, 9'd1, ln16, col16, ERR_NONE);
            cand_v[1] = 1'b1;
            cand_v[2] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // Position counters, saturating.
    line_nxt = line_r;
    col_nxt  = col_r;
    if (b_v == NL_BYTE) begin
      if (line_r < POS_MAX) begin
        line_nxt = line_r + POS_ONE;
      end
      col_nxt = POS_ONE;
    end else if (col_r < POS_MAX) begin
      col_nxt = col_r + POS_ONE;
    end

    // End of text: flush whatever is open, then return to the reset state.
    if (in_eot_r) begin
      idx2_ok = (cnt_nxt < CNT_W'(8));
      case (mode_nxt)
        M_NUMBER, M_IDENT: begin
          cand[3]   = mk_rec(REC_END, 8'h00, mode_kind(mode_nxt),
                             (mode_nxt == M_IDENT) ?
                               kw_code(mask_nxt, cnt_nxt[2:0], idx2_ok) : KW_NONE,
                             9'(cnt_nxt), 16'(tsl_nxt), 16'(tsc_nxt), ERR_NONE);
          cand_v[3] = 1'b1;
        end
        M_STRING: begin
          cand[3]   = mk_rec(REC_ERR, QUOTE_BYTE, TKN_NONE, KW_NONE, 9'd0,
                             16'(tsl_nxt), 16'(tsc_nxt), ERR_STRING);
          cand_v[3] = 1'b1;
        end
        M_SLASH: begin
          cand[3]   = mk_rec(REC_ERR, SLASH_BYTE, TKN_NONE, KW_NONE, 9'd0,
                             16'(tsl_nxt), 16'(tsc_nxt), ERR_SLASH);
          cand_v[3] = 1'b1;
        end
        default: begin
        end
      endcase
      mode_nxt = M_IDLE;
      mask_nxt = '1;
      cnt_nxt  = '0;
      line_nxt = POS_ONE;
      col_nxt  = POS_ONE;
      tsl_nxt  = POS_ONE;
      tsc_nxt  = POS_ONE;
    end else begin
      idx2_ok = 1'b0;
    end

    // Pack the valid slots in order and flag the last one.
    n_v = 3'd0;
    for (int i = 0; i < 3; i++) begin
      pack[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && n_v < 3'd3) begin
        pack[n_v[1:0]] = cand[i];
        n_v = n_v + 3'd1;
      end
    end
    if (n_v != 3'd0) begin
      pack[n_v[1:0] - 2'd1].last_of_run = 1'b1;
    end
    pack_n = n_v[1:0];
  end

  // Lexer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      mask_r <= '1;
      cnt_r  <= '0;
      line_r <= POS_ONE;
      col_r  <= POS_ONE;
      tsl_r  <= POS_ONE;
      tsc_r  <= POS_ONE;
    end else if (proc_fire) begin
      mode_r <= mode_nxt;
      mask_r <= mask_nxt;
      cnt_r  <= cnt_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      tsl_r  <= tsl_nxt;
      tsc_r  <= tsc_nxt;
    end
  end

  // Record buffer: fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= 2'd0;
    end else if (proc_fire) begin
      n_r <= pack_n;
    end else if (pop) begin
      n_r <= n_r - 2'd1;
    end
  end

  // Record buffer: payload, shifted toward the head as records leave.
  always_ff @(posedge clk) begin
    if (proc_fire) begin
      rec_r[0] <= pack[0];
      rec_r[1] <= pack[1];
      rec_r[2] <= pack[2];
    end else if (pop) begin
      rec_r[0] <= rec_r[1];
      rec_r[1] <= rec_r[2];
    end
  end

  // Output port.
  assign out_chan.valid        = (n_r != 2'd0);
  assign out_chan.record_kind  = rec_r[0].record_kind;
  assign out_chan.char_value   = rec_r[0].char_value;
  assign out_chan.token_kind   = rec_r[0].token_kind;
  assign out_chan.keyword_code = rec_r[0].keyword_code;
  assign out_chan.token_length = rec_r[0].token_length;
  assign out_chan.start_line   = rec_r[0].start_line;
  assign out_chan.start_column = rec_r[0].start_column;
  assign out_chan.error_code   = rec_r[0].error_code;
  assign out_chan.last_of_run  = rec_r[0].last_of_run;

`ifndef SYNTHESIS
  // A byte never gives more records than the buffer holds.
  a_slots_fit: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire |-> $countones(cand_v) <= 3)
    else $error("lexer produced more than three records for one byte");

  // The last record left in the buffer closes the run of its byte.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r == 2'd1) |-> rec_r[0].last_of_run)
    else $error("final buffered record lacks last_of_run");

  // Only the final record of a run carries the flag.
  a_last_only: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r > 2'd1) |-> !rec_r[0].last_of_run)
    else $error("last_of_run set on a record that is not last");

  // Error records always carry an error code; other records never do.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> ((out_chan.record_kind == REC_ERR) == (out_chan.error_code != ERR_NONE)))
    else $error("error code does not agree with record kind");

  // End of text returns the lexer to its reset state.
  a_eot_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && in_eot_r) |=> (mode_r == M_IDLE) && (line_r == POS_ONE) && (col_r == POS_ONE))
    else $error("lexer state not restored after end of text");
`endif

endmodule
